// ===== rtl/core/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// Shared constants and types of the line rasterizer: field widths, the
// controller states and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

    localparam int FIELD_BITS          = 6;
    localparam int COLOR_BITS          = 32;
    localparam int COORD_BITS_DEFAULT  = 6;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAW
    } blr_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } blr_cmd_t;

    typedef struct packed {
        logic at_end;
    } blr_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/blr_ctrl.sv =====
// ----------------------------------------------------------------------------
// blr_ctrl
// Controller of the line rasterizer: accepts a line request while idle,
// steps the datapath one pixel per free output slot and owns the valid
// flag of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_ctrl
    import blr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output blr_cmd_t         cmd,
    input  wire blr_status_t status
);

    blr_state_t state_reg;
    blr_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.at_end) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after the last pixel");

    a_load_starts_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_DRAW))
        else $error("accepted request did not start drawing");

    a_emit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emitted pixel not presented on the output");

endmodule

`default_nettype wire

// ===== rtl/core/blr_datapath.sv =====
// ----------------------------------------------------------------------------
// blr_datapath
// Datapath of the line rasterizer: line setup (axis swap, endpoint order,
// spans, initial decision value), the per-pixel Bresenham step and the
// output pixel register.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_datapath
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire blr_cmd_t              cmd,
    output blr_status_t                status,
    input  wire logic [FIELD_BITS-1:0] s_start_x,
    input  wire logic [FIELD_BITS-1:0] s_start_y,
    input  wire logic [FIELD_BITS-1:0] s_end_x,
    input  wire logic [FIELD_BITS-1:0] s_end_y,
    input  wire logic [COLOR_BITS-1:0] s_line_color,
    output logic [FIELD_BITS-1:0]      m_pixel_x,
    output logic [FIELD_BITS-1:0]      m_pixel_y,
    output logic [COLOR_BITS-1:0]      m_pixel_color,
    output logic                       m_last_pixel
);

    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + 3;

    logic [W-1:0]          major_pos_reg,  major_pos_next;
    logic [W-1:0]          minor_pos_reg,  minor_pos_next;
    logic [W-1:0]          major_end_reg,  major_end_next;
    logic [DW-1:0]         decision_reg,   decision_next;
    logic [W-1:0]          major_span_reg, major_span_next;
    logic [W-1:0]          minor_span_reg, minor_span_next;
    logic                  swapped_reg,    swapped_next;
    logic                  down_reg,       down_next;
    logic [COLOR_BITS-1:0] color_reg,      color_next;
    logic [FIELD_BITS-1:0] px_reg,         px_next;
    logic [FIELD_BITS-1:0] py_reg,         py_next;
    logic [COLOR_BITS-1:0] pcolor_reg,     pcolor_next;
    logic                  plast_reg,      plast_next;

    logic [W-1:0]  x0, y0, x1, y1;
    logic [W-1:0]  adx, ady;
    logic          steep;
    logic [W-1:0]  a0, b0, a1, b1;
    logic          flip;
    logic [W-1:0]  lo_a, lo_b, hi_a, hi_b;
    logic          new_down;
    logic [W-1:0]  new_minor_span;
    logic [W-1:0]  new_major_span;
    logic [DW-1:0] two_minor, two_major;
    logic          positive;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            major_end_reg  <= '0;
            decision_reg   <= '0;
            major_span_reg <= '0;
            minor_span_reg <= '0;
            swapped_reg    <= 1'b0;
            down_reg       <= 1'b0;
            color_reg      <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            pcolor_reg     <= '0;
            plast_reg      <= 1'b0;
        end else begin
            major_pos_reg  <= major_pos_next;
            minor_pos_reg  <= minor_pos_next;
            major_end_reg  <= major_end_next;
            decision_reg   <= decision_next;
            major_span_reg <= major_span_next;
            minor_span_reg <= minor_span_next;
            swapped_reg    <= swapped_next;
            down_reg       <= down_next;
            color_reg      <= color_next;
            px_reg         <= px_next;
            py_reg         <= py_next;
            pcolor_reg     <= pcolor_next;
            plast_reg      <= plast_next;
        end
    end

    // line setup from the request
    always_comb begin
        x0 = s_start_x[W-1:0];
        y0 = s_start_y[W-1:0];
        x1 = s_end_x[W-1:0];
        y1 = s_end_y[W-1:0];
        adx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        ady = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        steep = ady > adx;
        a0 = steep ? y0 : x0;
        b0 = steep ? x0 : y0;
        a1 = steep ? y1 : x1;
        b1 = steep ? x1 : y1;
        flip = a0 > a1;
        lo_a = flip ? a1 : a0;
        lo_b = flip ? b1 : b0;
        hi_a = flip ? a0 : a1;
        hi_b = flip ? b0 : b1;
        new_major_span = hi_a - lo_a;
        new_down       = hi_b < lo_b;
        new_minor_span = new_down ? (lo_b - hi_b) : (hi_b - lo_b);
    end

    assign two_minor     = DW'({minor_span_reg, 1'b0});
    assign two_major     = DW'({major_span_reg, 1'b0});
    assign positive      = !decision_reg[DW-1] && (|decision_reg);
    assign status.at_end = major_pos_reg == major_end_reg;

    always_comb begin
        major_pos_next  = major_pos_reg;
        minor_pos_next  = minor_pos_reg;
        major_end_next  = major_end_reg;
        decision_next   = decision_reg;
        major_span_next = major_span_reg;
        minor_span_next = minor_span_reg;
        swapped_next    = swapped_reg;
        down_next       = down_reg;
        color_next      = color_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pcolor_next     = pcolor_reg;
        plast_next      = plast_reg;
        if (cmd.load) begin
            major_pos_next  = lo_a;
            minor_pos_next  = lo_b;
            major_end_next  = hi_a;
            major_span_next = new_major_span;
            minor_span_next = new_minor_span;
            swapped_next    = steep;
            down_next       = new_down;
            color_next      = s_line_color;
            decision_next   = DW'({new_minor_span, 1'b0}) - DW'(new_major_span);
        end else if (cmd.emit) begin
            px_next     = FIELD_BITS'(swapped_reg ? minor_pos_reg : major_pos_reg);
            py_next     = FIELD_BITS'(swapped_reg ? major_pos_reg : minor_pos_reg);
            pcolor_next = color_reg;
            plast_next  = status.at_end;
            if (!status.at_end) begin
                major_pos_next = major_pos_reg + W'(1);
                if (positive) begin
                    minor_pos_next = down_reg ? (minor_pos_reg - W'(1))
                                              : (minor_pos_reg + W'(1));
                    decision_next  = decision_reg + two_minor - two_major;
                end else begin
                    decision_next  = decision_reg + two_minor;
                end
            end
        end
    end

    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = pcolor_reg;
    assign m_last_pixel  = plast_reg;

    a_major_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (major_pos_reg <= major_end_reg))
        else $error("major position ran past the line end");

    a_major_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !status.at_end) |=>
            (major_pos_reg == $past(major_pos_reg) + W'(1)))
        else $error("major axis did not advance by one");

    a_decision_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> ($signed(decision_reg) <= $signed(two_minor)))
        else $error("decision value above twice the minor span");

endmodule

`default_nettype wire

// ===== rtl/core/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Top level of the Bresenham line rasterizer: controller plus datapath.
// ----------------------------------------------------------------------------
// A line request (two endpoints and a color) is taken while the block is
// idle. The line is walked along its major axis, both endpoints included,
// and each pixel leaves as one beat with its coordinates, the request color
// and last_pixel set on the final one. The datapath steps one pixel per
// cycle unless the output stalls; a line has 1 to 2**COORD_BITS pixels.
// The next request is accepted as soon as the last pixel sits in the
// output register. Coordinates use the low COORD_BITS bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FIELD_BITS-1:0] s_start_x,
    input  wire logic [FIELD_BITS-1:0] s_start_y,
    input  wire logic [FIELD_BITS-1:0] s_end_x,
    input  wire logic [FIELD_BITS-1:0] s_end_y,
    input  wire logic [COLOR_BITS-1:0] s_line_color,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [FIELD_BITS-1:0]      m_pixel_x,
    output logic [FIELD_BITS-1:0]      m_pixel_y,
    output logic [COLOR_BITS-1:0]      m_pixel_color,
    output logic                       m_last_pixel
);

    blr_cmd_t    cmd;
    blr_status_t status;

    blr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    blr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_line_color  (s_line_color),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

`default_nettype wire

// ===== tb/bresenham_line_rasterizer_checker.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_checker
// Watches both channels of the line rasterizer. Each accepted line request is
// walked with its own Bresenham stepper into a queue of expected pixels, and
// every accepted output beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_checker
    import blr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [FIELD_BITS-1:0] s_start_x,
    input  logic [FIELD_BITS-1:0] s_start_y,
    input  logic [FIELD_BITS-1:0] s_end_x,
    input  logic [FIELD_BITS-1:0] s_end_y,
    input  logic [COLOR_BITS-1:0] s_line_color,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [FIELD_BITS-1:0] m_pixel_x,
    input  logic [FIELD_BITS-1:0] m_pixel_y,
    input  logic [COLOR_BITS-1:0] m_pixel_color,
    input  logic                  m_last_pixel,
    output int                    mismatches,
    output int                    pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    pixel_t pixel_queue[$];

    initial begin
        mismatches     = 0;
        pixels_pending = 0;
    end

    task automatic rasterize_line(input int x0, input int y0, input int x1, input int y1,
                                  input logic [COLOR_BITS-1:0] color);
        int     maj, mnr, maj_end, mnr_end, tmp, span_maj, span_mnr, err, step;
        bit     steep, done;
        pixel_t px;
        steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
        maj     = steep ? y0 : x0;
        mnr     = steep ? x0 : y0;
        maj_end = steep ? y1 : x1;
        mnr_end = steep ? x1 : y1;
        if (maj > maj_end) begin
            tmp = maj; maj = maj_end; maj_end = tmp;
            tmp = mnr; mnr = mnr_end; mnr_end = tmp;
        end
        span_maj = maj_end - maj;
        step     = (mnr_end < mnr) ? -1 : 1;
        span_mnr = (mnr_end < mnr) ? mnr - mnr_end : mnr_end - mnr;
        err      = 2 * span_mnr - span_maj;
        done     = 1'b0;
        while (!done) begin
            px.x     = FIELD_BITS'(steep ? mnr : maj);
            px.y     = FIELD_BITS'(steep ? maj : mnr);
            px.color = color;
            px.last  = (maj == maj_end);
            pixel_queue.push_back(px);
            if (px.last) begin
                done = 1'b1;
            end else begin
                if (err > 0) begin
                    mnr = mnr + step;
                    err = err - 2 * span_maj;
                end
                err = err + 2 * span_mnr;
                maj = maj + 1;
            end
        end
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                             m_pixel_x, m_pixel_y, m_pixel_color, m_last_pixel);
                    mismatches++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (m_pixel_x !== want.x) begin
                        $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, m_pixel_x);
                        mismatches++;
                    end
                    if (m_pixel_y !== want.y) begin
                        $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, m_pixel_y);
                        mismatches++;
                    end
                    if (m_pixel_color !== want.color) begin
                        $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                                 m_pixel_color);
                        mismatches++;
                    end
                    if (m_last_pixel !== want.last) begin
                        $display("%0t: last_pixel expected %b actual %b", $time, want.last,
                                 m_last_pixel);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                rasterize_line(int'(s_start_x), int'(s_start_y), int'(s_end_x),
                               int'(s_end_y), s_line_color);
            end
            pixels_pending = pixel_queue.size();
        end
    end

endmodule

// ===== tb/bresenham_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_tb
// Drives line requests into the rasterizer: directed extremes (single pixel,
// full-length horizontal, vertical and diagonal lines, both step directions,
// zero decision value) then random short and long lines, with random idling
// on both channels and a long output stall. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb
    import blr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_LINES = 112;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 80;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [FIELD_BITS-1:0] s_start_x    = '0;
    logic [FIELD_BITS-1:0] s_start_y    = '0;
    logic [FIELD_BITS-1:0] s_end_x      = '0;
    logic [FIELD_BITS-1:0] s_end_y      = '0;
    logic [COLOR_BITS-1:0] s_line_color = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [FIELD_BITS-1:0] m_pixel_x;
    logic [FIELD_BITS-1:0] m_pixel_y;
    logic [COLOR_BITS-1:0] m_pixel_color;
    logic                  m_last_pixel;

    int mismatches;
    int pixels_pending;
    int lines_sent = 0;
    bit burst_mode = 1'b0;

    bresenham_line_rasterizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_line_color  (s_line_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

    bresenham_line_rasterizer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .s_line_color   (s_line_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_color  (m_pixel_color),
        .m_last_pixel   (m_last_pixel),
        .mismatches     (mismatches),
        .pixels_pending (pixels_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_gap();
        if (burst_mode || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int near_coord(input int base);
        int v;
        v = base + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 63) v = 63;
        return v;
    endfunction

    task automatic send_line(input int x0, input int y0, input int x1, input int y1,
                             input logic [COLOR_BITS-1:0] color);
        int gap;
        s_valid      <= 1'b1;
        s_start_x    <= FIELD_BITS'(x0);
        s_start_y    <= FIELD_BITS'(y0);
        s_end_x      <= FIELD_BITS'(x1);
        s_end_y      <= FIELD_BITS'(y1);
        s_line_color <= color;
        do @(posedge aclk); while (!s_ready);
        lines_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_all_drawn();
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (pixels_pending == 0);
        @(posedge aclk);
    endtask

    // sink: random backpressure, one long hold while requests keep coming
    initial begin : sink
        int  run_len, stall_len;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        wait (aresetn);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (!long_hold_done && lines_sent >= 40) begin
                long_hold_done = 1'b1;
                stall_len = LONG_HOLD;
            end else if ($urandom_range(0, 9) < 8) begin
                stall_len = $urandom_range(0, 3);
            end else begin
                stall_len = $urandom_range(10, 50);
            end
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("bresenham_line_rasterizer_tb failed");
                $finish;
            end
        end
    end

    initial begin : source
        int x0, y0, x1, y1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_line(0, 0, 0, 0, 32'h0000_0000);
        send_line(63, 63, 63, 63, 32'hFFFF_FFFF);
        send_line(0, 0, 63, 0, 32'hA5A5_A5A5);
        send_line(63, 5, 0, 5, 32'h5A5A_5A5A);
        send_line(7, 0, 7, 63, 32'h0123_4567);
        send_line(9, 63, 9, 0, 32'h89AB_CDEF);
        send_line(0, 0, 63, 63, 32'hFF00_FF00);
        send_line(63, 0, 0, 63, 32'h00FF_00FF);
        send_line(0, 0, 2, 1, 32'h8000_0001);
        send_line(10, 10, 14, 12, 32'h7FFF_FFFE);
        send_line(0, 0, 20, 63, 32'hDEAD_BEEF);
        send_line(40, 50, 30, 0, 32'hCAFE_F00D);
        send_line(0, 40, 63, 10, 32'h1357_9BDF);
        send_line(63, 0, 0, 1, 32'h2468_ACE0);
        send_line(1, 2, 2, 1, 32'hF0F0_F0F0);
        send_line(62, 1, 1, 62, 32'h0F0F_0F0F);
        send_line(21, 42, 42, 21, 32'hFFFF_0000);
        send_line(32, 31, 31, 32, 32'h0000_FFFF);
        wait_all_drawn();

        for (int n = 0; n < RANDOM_LINES; n++) begin
            burst_mode = (n >= 20 && n < 45);
            if (n == 90) wait_all_drawn();
            x0 = $urandom_range(0, 63);
            y0 = $urandom_range(0, 63);
            case ($urandom_range(0, 9))
                0: begin
                    x1 = x0;
                    y1 = y0;
                end
                1, 2, 3: begin
                    x1 = $urandom_range(0, 63);
                    y1 = $urandom_range(0, 63);
                end
                default: begin
                    x1 = near_coord(x0);
                    y1 = near_coord(y0);
                end
            endcase
            send_line(x0, y0, x1, y1, $urandom());
        end
        s_valid <= 1'b0;

        wait_all_drawn();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pixels_pending != 0)
            $display("%0t: %0d expected pixels never arrived", $time, pixels_pending);
        if (mismatches == 0 && pixels_pending == 0) begin
            $display("bresenham_line_rasterizer_tb passed");
        end else begin
            $display("bresenham_line_rasterizer_tb failed");
        end
        $finish;
    end

endmodule
